>>> sv/qpli_pkg.sv
// Shared types, constants and tap tables of the quarter-pel luma interpolator.
// No dependencies; every other file of the block but qpli_ram uses this package.
package qpli_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int ROW_LEN    = MAX_WIDTH + 3;
    localparam int STORE_DEPTH = 4 * ROW_LEN;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int DIM_W      = 7;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SELECT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 2'd3;

    localparam logic [1:0] TAPS_HALF = 2'd2;

    // Sub-pel positions.
    localparam logic [3:0] POS_COPY   = 4'd0;
    localparam logic [3:0] POS_H1     = 4'd1;
    localparam logic [3:0] POS_H2     = 4'd2;
    localparam logic [3:0] POS_H3     = 4'd3;
    localparam logic [3:0] POS_V1     = 4'd4;
    localparam logic [3:0] POS_HV     = 4'd5;
    localparam logic [3:0] POS_HC     = 4'd6;
    localparam logic [3:0] POS_HVR    = 4'd7;
    localparam logic [3:0] POS_V2     = 4'd8;
    localparam logic [3:0] POS_VC     = 4'd9;
    localparam logic [3:0] POS_CENTRE = 4'd10;
    localparam logic [3:0] POS_VRC    = 4'd11;
    localparam logic [3:0] POS_V3     = 4'd12;
    localparam logic [3:0] POS_VHB    = 4'd13;
    localparam logic [3:0] POS_HBC    = 4'd14;
    localparam logic [3:0] POS_VRHB   = 4'd15;

    // Steps of the shared filter unit.
    localparam logic [3:0] OP_ROW0    = 4'd0;
    localparam logic [3:0] OP_ROW1    = 4'd1;
    localparam logic [3:0] OP_ROW2    = 4'd2;
    localparam logic [3:0] OP_ROW3    = 4'd3;
    localparam logic [3:0] OP_COL0    = 4'd4;
    localparam logic [3:0] OP_COL1    = 4'd5;
    localparam logic [3:0] OP_CENTRE  = 4'd6;
    localparam logic [3:0] OP_PLAIN_H = 4'd7;
    localparam logic [3:0] OP_PLAIN_V = 4'd8;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FETCH,
        ST_FILT,
        ST_OUT
    } t_state;

    typedef logic [PIX_W-1:0] t_px4 [4];

    // Tap k of tap set sel; set 0 is all zero.
    function automatic logic signed [5:0] tap(input logic [1:0] sel, input logic [1:0] k);
        logic signed [5:0] t;
        t = 6'sd0;
        case (sel)
            2'd1: begin
                case (k)
                    2'd0: t = -6'sd1;
                    2'd1: t = 6'sd25;
                    2'd2: t = 6'sd9;
                    default: t = -6'sd1;
                endcase
            end
            2'd2: begin
                case (k)
                    2'd0: t = -6'sd2;
                    2'd1: t = 6'sd18;
                    2'd2: t = 6'sd18;
                    default: t = -6'sd2;
                endcase
            end
            2'd3: begin
                case (k)
                    2'd0: t = -6'sd1;
                    2'd1: t = 6'sd9;
                    2'd2: t = 6'sd25;
                    default: t = -6'sd1;
                endcase
            end
            default: t = 6'sd0;
        endcase
        return t;
    endfunction

endpackage

>>> sv/qpli_in_if.sv
// Input stream channel of the interpolator: one reference pixel per transfer.
// Depends on qpli_pkg.
interface qpli_in_if;
    logic                       valid;
    logic                       ready;
    logic [qpli_pkg::PIX_W-1:0] ref_pixel;

    modport source (output valid, output ref_pixel, input ready);
    modport sink   (input valid, input ref_pixel, output ready);
endinterface

>>> sv/qpli_out_if.sv
// Output stream channel of the interpolator: one interpolated pixel per transfer.
// Depends on qpli_pkg.
interface qpli_out_if;
    logic                       valid;
    logic                       ready;
    logic [qpli_pkg::PIX_W-1:0] out_pixel;
    logic                       row_end;
    logic                       block_end;

    modport source (output valid, output out_pixel, output row_end, output block_end,
                    input ready);
    modport sink   (input valid, input out_pixel, input row_end, input block_end,
                    output ready);
endinterface

>>> sv/qpli_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module qpli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/qpli_filt.sv
// Shared 4-tap filter unit: weighted sum, rounding, shift by five and clamp to 0..255.
// Depends on qpli_pkg for the tap tables and pixel types.
module qpli_filt (
    input  qpli_pkg::t_px4                  i_px,
    input  logic [1:0]                      i_sel,
    output logic [qpli_pkg::PIX_W-1:0]      o_pix
);
    logic signed [15:0] sum;
    logic signed [15:0] rnd;
    logic signed [15:0] shf;

    always_comb begin
        sum = 16'sd0;
        for (int k = 0; k < 4; k++) begin
            sum = sum + 16'(qpli_pkg::tap(i_sel, 2'(k)) * $signed({1'b0, i_px[k]}));
        end
        rnd = sum + 16'sd16;
        shf = rnd >>> 5;
        if (rnd[15]) begin
            o_pix = '0;
        end else if (shf > 16'sd255) begin
            o_pix = 8'd255;
        end else begin
            o_pix = shf[7:0];
        end
    end
endmodule

>>> sv/quarter_pel_luma_interpolator.sv
// Quarter-pel luma interpolator with 4-tap filters.
// Input channel i_in carries the reference window, (width+3) by (height+3) pixels
// in raster order, starting one row up and one column left of the block. Output
// channel o_out carries the interpolated block, one pixel per transfer, with
// row_end on the last pixel of each row and block_end on the last pixel of the block.
// A window pixel is taken on each valid transfer while the block loads a window row. When a
// window row from the fourth on is complete, the input stalls while the output row
// is made: each pixel reads its 4x4 neighborhood from the single registered read port
// of the line store (16 reads), passes through the steps of the shared filter unit
// and is then handed to the output register.
// The output register lets the next pixel be worked on while a finished one waits;
// if the receiver stalls, the block holds in its output step until the transfer.
// Configuration writes take effect at once and restart the window at its first pixel.
// Reset restores position_mode 0, coef_select 0, width and height 8 and an empty
// window; the line store is not cleared, since each block only reads rows it wrote.
// Depends on qpli_pkg, qpli_in_if, qpli_out_if, qpli_ram and qpli_filt.
module quarter_pel_luma_interpolator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qpli_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [qpli_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    qpli_in_if.sink                             i_in,
    qpli_out_if.source                          o_out
);
    localparam int PW = qpli_pkg::PIX_W;
    localparam int AW = qpli_pkg::ADDR_W;
    localparam int DW = qpli_pkg::DIM_W;
    localparam int XW = qpli_pkg::X_W;

    qpli_pkg::t_state r_state, n_state;

    logic [3:0]    r_mode;
    logic [1:0]    r_coef;
    logic [DW-1:0] r_bw, r_bh;
    logic [DW-1:0] r_col, r_row;
    logic [DW-1:0] r_y;
    logic [XW-1:0] r_x;
    logic [4:0]    r_k;
    logic [3:0]    r_op;

    logic [PW-1:0] r_nb [16];
    logic [PW-1:0] r_hr [4];
    logic [PW-1:0] r_v0, r_v1, r_c, r_hs, r_vs;

    logic          r_ov;
    logic [PW-1:0] r_opix;
    logic          r_oend, r_bend;

    logic [DW-1:0] eff_w, eff_h;
    logic          in_xfer, out_take, out_load;
    logic          row_done, x_last;
    logic [1:0]    wslot, rslot;
    logic [AW-1:0] waddr, raddr;
    logic [PW-1:0] rdata;
    qpli_pkg::t_px4 fpx;
    logic [1:0]    fsel;
    logic [PW-1:0] fout;
    logic [PW-1:0] res;
    logic [PW-1:0] avg_a, avg_b;
    logic [PW:0]   avg_s;

    always_comb begin
        if (r_bw == '0) begin
            eff_w = DW'(1);
        end else if (r_bw > DW'(qpli_pkg::MAX_WIDTH)) begin
            eff_w = DW'(qpli_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_bw;
        end
        if (r_bh == '0) begin
            eff_h = DW'(1);
        end else if (r_bh > DW'(qpli_pkg::MAX_HEIGHT)) begin
            eff_h = DW'(qpli_pkg::MAX_HEIGHT);
        end else begin
            eff_h = r_bh;
        end
    end

    assign i_in.ready = (r_state == qpli_pkg::ST_LOAD);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_take   = r_ov && o_out.ready;
    assign out_load   = (r_state == qpli_pkg::ST_OUT) && (!r_ov || o_out.ready);
    assign row_done   = (r_col >= DW'(eff_w + DW'(2)));
    assign x_last     = (DW'({1'b0, r_x}) + DW'(1) == eff_w);

    // Line store addressing: slot times row length plus column.
    assign wslot = r_row[1:0];
    assign waddr = AW'(AW'(wslot) * AW'(qpli_pkg::ROW_LEN)) + AW'(r_col);
    assign rslot = 2'(r_y[1:0] + r_k[3:2]);
    assign raddr = AW'(AW'(rslot) * AW'(qpli_pkg::ROW_LEN)) + AW'(r_x) + AW'(r_k[1:0]);

    qpli_ram #(
        .WIDTH (PW),
        .DEPTH (qpli_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (waddr),
        .i_wdata (i_in.ref_pixel),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Operand selection for the shared filter: four half-pel row filters, two
    // half-pel column filters, the centre pass over the row results, then the
    // plain horizontal and vertical filters with the selected tap set.
    always_comb begin
        fsel = qpli_pkg::TAPS_HALF;
        fpx  = '{r_nb[0], r_nb[1], r_nb[2], r_nb[3]};
        case (r_op)
            qpli_pkg::OP_ROW0: fpx = '{r_nb[0], r_nb[1], r_nb[2], r_nb[3]};
            qpli_pkg::OP_ROW1: fpx = '{r_nb[4], r_nb[5], r_nb[6], r_nb[7]};
            qpli_pkg::OP_ROW2: fpx = '{r_nb[8], r_nb[9], r_nb[10], r_nb[11]};
            qpli_pkg::OP_ROW3: fpx = '{r_nb[12], r_nb[13], r_nb[14], r_nb[15]};
            qpli_pkg::OP_COL0: fpx = '{r_nb[1], r_nb[5], r_nb[9], r_nb[13]};
            qpli_pkg::OP_COL1: fpx = '{r_nb[2], r_nb[6], r_nb[10], r_nb[14]};
            qpli_pkg::OP_CENTRE: fpx = '{r_hr[0], r_hr[1], r_hr[2], r_hr[3]};
            qpli_pkg::OP_PLAIN_H: begin
                fpx  = '{r_nb[4], r_nb[5], r_nb[6], r_nb[7]};
                fsel = r_coef;
            end
            qpli_pkg::OP_PLAIN_V: begin
                fpx  = '{r_nb[1], r_nb[5], r_nb[9], r_nb[13]};
                fsel = r_coef;
            end
            default: fsel = qpli_pkg::TAPS_HALF;
        endcase
    end

    qpli_filt u_filt (
        .i_px  (fpx),
        .i_sel (fsel),
        .o_pix (fout)
    );

    // Final selection; r_hr[1] is the half-pel row result and r_hr[2] the one below.
    always_comb begin
        avg_a = r_hr[1];
        avg_b = r_v0;
        case (r_mode)
            qpli_pkg::POS_HV:   begin avg_a = r_hr[1]; avg_b = r_v0;    end
            qpli_pkg::POS_HC:   begin avg_a = r_hr[1]; avg_b = r_c;     end
            qpli_pkg::POS_HVR:  begin avg_a = r_hr[1]; avg_b = r_v1;    end
            qpli_pkg::POS_VC:   begin avg_a = r_v0;    avg_b = r_c;     end
            qpli_pkg::POS_VRC:  begin avg_a = r_v1;    avg_b = r_c;     end
            qpli_pkg::POS_VHB:  begin avg_a = r_v0;    avg_b = r_hr[2]; end
            qpli_pkg::POS_HBC:  begin avg_a = r_hr[2]; avg_b = r_c;     end
            qpli_pkg::POS_VRHB: begin avg_a = r_v1;    avg_b = r_hr[2]; end
            default: avg_a = r_hr[1];
        endcase
        avg_s = (PW+1)'({1'b0, avg_a} + {1'b0, avg_b} + (PW+1)'(1));
        case (r_mode)
            qpli_pkg::POS_COPY: res = r_nb[5];
            qpli_pkg::POS_H1, qpli_pkg::POS_H2, qpli_pkg::POS_H3: res = r_hs;
            qpli_pkg::POS_V1, qpli_pkg::POS_V2, qpli_pkg::POS_V3: res = r_vs;
            qpli_pkg::POS_CENTRE: res = r_c;
            default: res = avg_s[PW:1];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            qpli_pkg::ST_LOAD: begin
                if (in_xfer && row_done && r_row >= DW'(3)) begin
                    n_state = qpli_pkg::ST_FETCH;
                end
            end
            qpli_pkg::ST_FETCH: begin
                if (r_k == 5'd16) begin
                    n_state = qpli_pkg::ST_FILT;
                end
            end
            qpli_pkg::ST_FILT: begin
                if (r_op == qpli_pkg::OP_PLAIN_V) begin
                    n_state = qpli_pkg::ST_OUT;
                end
            end
            qpli_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = x_last ? qpli_pkg::ST_LOAD : qpli_pkg::ST_FETCH;
                end
            end
            default: n_state = qpli_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qpli_pkg::ST_LOAD;
            r_mode  <= '0;
            r_coef  <= '0;
            r_bw    <= DW'(8);
            r_bh    <= DW'(8);
            r_col   <= '0;
            r_row   <= '0;
            r_y     <= '0;
            r_x     <= '0;
            r_k     <= '0;
            r_op    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qpli_pkg::REG_POSITION_MODE: r_mode <= i_cfg_data[3:0];
                    qpli_pkg::REG_COEF_SELECT:   r_coef <= i_cfg_data[1:0];
                    qpli_pkg::REG_BLOCK_WIDTH:   r_bw   <= i_cfg_data;
                    qpli_pkg::REG_BLOCK_HEIGHT:  r_bh   <= i_cfg_data;
                    default: r_mode <= r_mode;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (in_xfer) begin
                if (row_done) begin
                    r_col <= '0;
                    r_y   <= DW'(r_row - DW'(3));
                    r_x   <= '0;
                    r_k   <= '0;
                    if (r_row >= DW'(eff_h + DW'(2))) begin
                        r_row <= '0;
                    end else begin
                        r_row <= DW'(r_row + DW'(1));
                    end
                end else begin
                    r_col <= DW'(r_col + DW'(1));
                end
            end
            if (r_state == qpli_pkg::ST_FETCH) begin
                r_k  <= 5'(r_k + 5'd1);
                r_op <= qpli_pkg::OP_ROW0;
            end
            if (r_state == qpli_pkg::ST_FILT) begin
                r_op <= 4'(r_op + 4'd1);
            end
            if (out_load) begin
                r_ov <= 1'b1;
                r_x  <= XW'(r_x + XW'(1));
                r_k  <= '0;
            end else if (out_take) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == qpli_pkg::ST_FETCH && r_k != 5'd0) begin
            r_nb[4'(r_k - 5'd1)] <= rdata;
        end
        if (r_state == qpli_pkg::ST_FILT) begin
            case (r_op)
                qpli_pkg::OP_ROW0:    r_hr[0] <= fout;
                qpli_pkg::OP_ROW1:    r_hr[1] <= fout;
                qpli_pkg::OP_ROW2:    r_hr[2] <= fout;
                qpli_pkg::OP_ROW3:    r_hr[3] <= fout;
                qpli_pkg::OP_COL0:    r_v0    <= fout;
                qpli_pkg::OP_COL1:    r_v1    <= fout;
                qpli_pkg::OP_CENTRE:  r_c     <= fout;
                qpli_pkg::OP_PLAIN_H: r_hs    <= fout;
                qpli_pkg::OP_PLAIN_V: r_vs    <= fout;
                default: r_vs <= r_vs;
            endcase
        end
        if (out_load) begin
            r_opix <= res;
            r_oend <= x_last;
            r_bend <= x_last && (DW'(r_y + DW'(1)) == eff_h);
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_pixel = r_opix;
    assign o_out.row_end   = r_oend;
    assign o_out.block_end = r_bend;

`ifndef SYNTHESIS
    a_block_end_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.block_end |-> o_out.row_end)
        else $error("block_end without row_end");

    a_no_input_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qpli_pkg::ST_FETCH || r_state == qpli_pkg::ST_FILT) |-> !i_in.ready)
        else $error("input accepted while an output pixel is in progress");

    a_x_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qpli_pkg::ST_FETCH) |-> (DW'({1'b0, r_x}) < eff_w))
        else $error("output column beyond block width");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out.valid)
        else $error("finished pixel not presented");
`endif

endmodule
